FILE: hdl/gmmcd_pkg.sv
// package: widths, codes and word types of the group aggregate block
`timescale 1ns / 1ps

package gmmcd_pkg;

    // distinct key space
    localparam int KEY_BITS   = 12;
    localparam int MAP_DEPTH  = 1 << KEY_BITS;
    localparam int DEPTH_BITS = KEY_BITS + 1;

    // counts saturate at the largest positive 32-bit value
    localparam int CNT_BITS = 31;
    localparam logic [CNT_BITS-1:0] COUNT_MAX = '1;

    // configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_AGG_MODE       = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DISTINCT       = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INPUT_DISTINCT = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ERROR_SKIP     = 2'd3;

    typedef enum logic [1:0] {
        MODE_MAX       = 2'd0,
        MODE_MIN       = 2'd1,
        MODE_COUNT     = 2'd2,
        MODE_COUNT_ALL = 2'd3
    } agg_mode_t;

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_NULL    = 2'd2;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOKUP,
        ST_READ0,
        ST_RESULT,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic signed [31:0] row_value;
        logic               value_ok;
        logic               row_present;
        logic               last_of_group;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
        logic               key_out_of_range;
    } out_word_t;

endpackage

FILE: hdl/group_min_max_count_distinct.sv
// top level: streaming group min, max, count and count distinct
`timescale 1ns / 1ps

// channel | signals                          | direction | word
// in      | in_valid, in_stall, in_data      | into      | in_word_t, one row
// out     | out_valid, out_stall, out_data   | out of    | out_word_t, one result
// cfg     | cfg_valid, cfg_ready, cfg_index, | into      | register write
//         | cfg_data                         |           |
//
// a row passes through idle, and also through the lookup state when a distinct key is
// looked up in the seen bitmap; a group end adds the key zero lookup and result states
// and then a stack walk that clears the bitmap through its single write port
// after reset all 4096 bitmap entries are cleared before the first row
// the result sits in an output register; out_stall only holds the result state
module group_min_max_count_distinct
    import gmmcd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  in_word_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output out_word_t                out_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    // configuration registers
    agg_mode_t agg_mode_reg;
    logic      distinct_reg;
    logic      input_distinct_reg;
    logic      error_skip_reg;

    // control and group state
    state_t                 state_reg, state_next;
    logic [KEY_BITS-1:0]    init_cnt_reg, init_cnt_next;
    logic signed [31:0]     ext_reg, ext_next;
    logic                   have_reg, have_next;
    logic [CNT_BITS-1:0]    valid_cnt_reg, valid_cnt_next;
    logic [CNT_BITS-1:0]    invalid_cnt_reg, invalid_cnt_next;
    logic [CNT_BITS-1:0]    dist_cnt_reg, dist_cnt_next;
    logic [DEPTH_BITS-1:0]  depth_reg, depth_next;
    logic                   range_reg, range_next;
    logic                   walk_pend_reg, walk_pend_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic                   last_reg, last_next;
    logic                   out_valid_reg, out_valid_next;
    out_word_t              out_data_reg, out_data_next;

    // memories
    logic                   seen_mem [MAP_DEPTH];
    logic [KEY_BITS-1:0]    stack_mem [MAP_DEPTH];
    logic                   seen_we, seen_wbit, seen_re, seen_rdata_reg;
    logic [KEY_BITS-1:0]    seen_waddr, seen_raddr;
    logic                   stk_we, stk_re;
    logic [KEY_BITS-1:0]    stk_waddr, stk_raddr, stk_rdata_reg;

    logic      dpath;
    logic      accept;
    logic      key_in_range;
    logic      lookup_req;
    logic      out_free;
    out_word_t result;
    logic [31:0]         sum_cnt;
    logic [CNT_BITS-1:0] sum_sat;
    logic [CNT_BITS-1:0] dist_res;

    function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] c);
        sat_inc = (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    assign dpath        = (agg_mode_reg == MODE_COUNT) && distinct_reg && !input_distinct_reg;
    assign in_stall     = (state_reg != ST_IDLE);
    assign accept       = in_valid && !in_stall;
    assign key_in_range = (in_data.row_value[31:KEY_BITS] == '0);
    assign lookup_req   = in_data.row_present && in_data.value_ok && dpath && key_in_range;
    assign out_free     = !out_valid_reg || !out_stall;
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            agg_mode_reg       <= MODE_MAX;
            distinct_reg       <= 1'b0;
            input_distinct_reg <= 1'b0;
            error_skip_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_AGG_MODE:       agg_mode_reg       <= agg_mode_t'(cfg_data);
                CFG_DISTINCT:       distinct_reg       <= cfg_data[0];
                CFG_INPUT_DISTINCT: input_distinct_reg <= cfg_data[0];
                CFG_ERROR_SKIP:     error_skip_reg     <= cfg_data[0];
            endcase
        end
    end

    // result of the closing group
    assign sum_cnt  = {1'b0, valid_cnt_reg} + {1'b0, invalid_cnt_reg};
    assign sum_sat  = sum_cnt[31] ? COUNT_MAX : sum_cnt[CNT_BITS-1:0];
    assign dist_res = (!error_skip_reg && (invalid_cnt_reg != '0) && !seen_rdata_reg)
                      ? sat_inc(dist_cnt_reg) : dist_cnt_reg;

    always_comb
    begin
        result.result_value     = '0;
        result.status           = STAT_OK;
        result.key_out_of_range = 1'b0;
        if ((agg_mode_reg == MODE_MAX) || (agg_mode_reg == MODE_MIN))
        begin
            if (have_reg)
                result.result_value = ext_reg;
            else
                result.status = STAT_INVALID;
        end
        else if ((valid_cnt_reg == '0) && (invalid_cnt_reg == '0))
        begin
            result.status = STAT_NULL;
        end
        else if (!dpath)
        begin
            if (error_skip_reg)
            begin
                result.result_value = {1'b0, valid_cnt_reg};
                if (valid_cnt_reg == '0)
                    result.status = STAT_INVALID;
            end
            else
            begin
                result.result_value = {1'b0, sum_sat};
            end
        end
        else
        begin
            result.key_out_of_range = range_reg;
            if (valid_cnt_reg == '0)
            begin
                if (error_skip_reg)
                    result.status = STAT_INVALID;
                else
                    result.result_value = 32'sd1;
            end
            else if (dist_res == '0)
            begin
                result.status = STAT_INVALID;
            end
            else
            begin
                result.result_value = {1'b0, dist_res};
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (init_cnt_reg == '1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (lookup_req)
                        state_next = ST_LOOKUP;
                    else if (in_data.last_of_group)
                        state_next = ST_READ0;
                end
            end
            ST_LOOKUP: state_next = last_reg ? ST_READ0 : ST_IDLE;
            ST_READ0:  state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (out_free)
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (depth_reg == '0)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_INIT;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        init_cnt_next    = init_cnt_reg;
        ext_next         = ext_reg;
        have_next        = have_reg;
        valid_cnt_next   = valid_cnt_reg;
        invalid_cnt_next = invalid_cnt_reg;
        dist_cnt_next    = dist_cnt_reg;
        depth_next       = depth_reg;
        range_next       = range_reg;
        walk_pend_next   = walk_pend_reg;
        key_next         = key_reg;
        last_next        = last_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_data_next    = out_data_reg;
        seen_we          = 1'b0;
        seen_waddr       = key_reg;
        seen_wbit        = 1'b0;
        seen_re          = 1'b0;
        seen_raddr       = key_reg;
        stk_we           = 1'b0;
        stk_waddr        = depth_reg[KEY_BITS-1:0];
        stk_re           = 1'b0;
        stk_raddr        = depth_reg[KEY_BITS-1:0] - 1'b1;

        unique case (state_reg)
            ST_INIT:
            begin
                // clear one bitmap entry per cycle
                seen_we       = 1'b1;
                seen_waddr    = init_cnt_reg;
                init_cnt_next = init_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next  = in_data.row_value[KEY_BITS-1:0];
                    last_next = in_data.last_of_group;
                    if (in_data.row_present)
                    begin
                        if ((agg_mode_reg == MODE_MAX) || (agg_mode_reg == MODE_MIN))
                        begin
                            // fold into the running extreme
                            if (in_data.value_ok || !error_skip_reg)
                            begin
                                if (!have_reg ||
                                    ((agg_mode_reg == MODE_MAX) &&
                                     (in_data.row_value > ext_reg)) ||
                                    ((agg_mode_reg == MODE_MIN) &&
                                     (in_data.row_value < ext_reg)))
                                    ext_next = in_data.row_value;
                                have_next = 1'b1;
                            end
                        end
                        else
                        begin
                            // row counts
                            if ((agg_mode_reg == MODE_COUNT_ALL) || in_data.value_ok)
                                valid_cnt_next = sat_inc(valid_cnt_reg);
                            else
                                invalid_cnt_next = sat_inc(invalid_cnt_reg);
                            if (dpath && in_data.value_ok && !key_in_range)
                                range_next = 1'b1;
                        end
                    end
                    // look the key up in the bitmap
                    if (lookup_req)
                    begin
                        seen_re    = 1'b1;
                        seen_raddr = in_data.row_value[KEY_BITS-1:0];
                    end
                end
            end
            ST_LOOKUP:
            begin
                // first sighting: mark it and push the key
                if (!seen_rdata_reg && !depth_reg[KEY_BITS])
                begin
                    seen_we       = 1'b1;
                    seen_wbit     = 1'b1;
                    stk_we        = 1'b1;
                    depth_next    = depth_reg + 1'b1;
                    dist_cnt_next = sat_inc(dist_cnt_reg);
                end
            end
            ST_READ0:
            begin
                seen_re    = 1'b1;
                seen_raddr = '0;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_data_next    = result;
                    ext_next         = '0;
                    have_next        = 1'b0;
                    valid_cnt_next   = '0;
                    invalid_cnt_next = '0;
                    dist_cnt_next    = '0;
                    range_next       = 1'b0;
                    walk_pend_next   = 1'b0;
                end
            end
            ST_WALK:
            begin
                // clear the key popped last cycle, pop the next one
                if (walk_pend_reg)
                begin
                    seen_we    = 1'b1;
                    seen_waddr = stk_rdata_reg;
                end
                if (depth_reg != '0)
                begin
                    stk_re         = 1'b1;
                    depth_next     = depth_reg - 1'b1;
                    walk_pend_next = 1'b1;
                end
                else
                begin
                    walk_pend_next = 1'b0;
                end
            end
            default:
            begin
                init_cnt_next = '0;
            end
        endcase
    end

    // control and group registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            init_cnt_reg    <= '0;
            ext_reg         <= '0;
            have_reg        <= 1'b0;
            valid_cnt_reg   <= '0;
            invalid_cnt_reg <= '0;
            dist_cnt_reg    <= '0;
            depth_reg       <= '0;
            range_reg       <= 1'b0;
            walk_pend_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            init_cnt_reg    <= init_cnt_next;
            ext_reg         <= ext_next;
            have_reg        <= have_next;
            valid_cnt_reg   <= valid_cnt_next;
            invalid_cnt_reg <= invalid_cnt_next;
            dist_cnt_reg    <= dist_cnt_next;
            depth_reg       <= depth_next;
            range_reg       <= range_next;
            walk_pend_reg   <= walk_pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    // seen bitmap
    always_ff @(posedge clk)
    begin
        if (seen_we)
            seen_mem[seen_waddr] <= seen_wbit;
        if (seen_re)
            seen_rdata_reg <= seen_mem[seen_raddr];
    end

    // key stack
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[stk_waddr] <= key_reg;
        if (stk_re)
            stk_rdata_reg <= stack_mem[stk_raddr];
    end

    // stack never holds more keys than the bitmap has entries
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_BITS'(MAP_DEPTH))
        else $error("key stack depth above bitmap size");

    // between groups every pushed key is one distinct key found
    a_depth_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ({{(CNT_BITS-DEPTH_BITS){1'b0}}, depth_reg} == dist_cnt_reg))
        else $error("stack depth and distinct count disagree");

    // walk hands back to idle only with an empty stack
    a_walk_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WALK) && (state_next == ST_IDLE)) |-> (depth_reg == '0))
        else $error("walk left keys in the bitmap");

    // a result that is not ok carries a zero value
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.status != STAT_OK)) |-> (out_data_reg.result_value == '0))
        else $error("non-ok result with a nonzero value");

endmodule
